>>> hdl/triangle_unit_box_overlap_test_core_macros.svh
// Assertion macros for the triangle versus unit box overlap core.
// Depends on nothing; included by the top level only.
`ifndef TRIANGLE_UNIT_BOX_OVERLAP_TEST_CORE_MACROS_SVH
`define TRIANGLE_UNIT_BOX_OVERLAP_TEST_CORE_MACROS_SVH

// Same-cycle or delayed implication, consequent given as a sequence.
`define TUB_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
      else $error(msg);

// Next-cycle implication.
`define TUB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/tubo_pkg.sv
// Package for the triangle versus unit box overlap core: widths and edge tables.
// Depends on nothing.
`timescale 1ns / 1ps

package tubo_pkg;

   localparam int CW   = 24;              // coordinate width
   localparam int FRAC = 12;              // fraction bits
   localparam int EW   = CW + 1;          // edge vector width
   localparam int PW   = EW + CW;         // product width
   localparam int DW   = PW + 1;          // projection width
   localparam int XW   = EW + 1 + FRAC;   // box extent width, unsigned
   localparam int CMPW = (DW > XW + 1) ? DW : XW + 1;
   localparam int NEDGE = 3;

   localparam logic signed [CMPW-1:0] ONE = CMPW'(1) <<< FRAC;

   // Edge k runs from vertex k to EDGE_B[k]; EDGE_C[k] is the opposite vertex.
   localparam int EDGE_B [NEDGE] = '{1, 2, 0};
   localparam int EDGE_C [NEDGE] = '{2, 0, 1};

endpackage

>>> hdl/triangle_unit_box_overlap_test_core.sv
// Top level of the triangle versus unit box overlap core: four-stage pipeline.
// Depends on tubo_pkg and triangle_unit_box_overlap_test_core_macros.svh.
`timescale 1ns / 1ps
`include "triangle_unit_box_overlap_test_core_macros.svh"

// Takes one triangle per clock and answers whether it touches or overlaps the
// square [-1, +1] x [-1, +1]. busy is always low, so a request is taken at every
// clock edge with start high. The answer appears on rsp_overlaps with rsp_valid
// high for one cycle, in request order, once the request has passed the pipeline;
// the receiver must take it then. The pipeline stages are edge vectors and box
// axes, twelve 25x24 products, projection differences, and the final compare
// against the box extent. Sustained rate is one triangle per cycle.
module triangle_unit_box_overlap_test_core
   import tubo_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic signed [CW-1:0] req_x0,
   input  logic signed [CW-1:0] req_y0,
   input  logic signed [CW-1:0] req_x1,
   input  logic signed [CW-1:0] req_y1,
   input  logic signed [CW-1:0] req_x2,
   input  logic signed [CW-1:0] req_y2,
   output logic                 rsp_valid,
   output logic                 rsp_overlaps
);

   logic signed [CW-1:0] vx [NEDGE];
   logic signed [CW-1:0] vy [NEDGE];

   // stage 1: edge vectors, box axes
   logic                 s1_valid_ff, s1_valid_in;
   logic                 s1_box_sep_ff, s1_box_sep_in;
   logic signed [EW-1:0] s1_ex_ff [NEDGE], s1_ex_in [NEDGE];
   logic signed [EW-1:0] s1_ey_ff [NEDGE], s1_ey_in [NEDGE];
   logic signed [CW-1:0] s1_ax_ff [NEDGE], s1_ay_ff [NEDGE];
   logic signed [CW-1:0] s1_cx_ff [NEDGE], s1_cy_ff [NEDGE];

   // stage 2: products, box extent
   logic                 s2_valid_ff, s2_box_sep_ff;
   logic signed [PW-1:0] s2_eyax_ff [NEDGE], s2_eyax_in [NEDGE];
   logic signed [PW-1:0] s2_exay_ff [NEDGE], s2_exay_in [NEDGE];
   logic signed [PW-1:0] s2_eycx_ff [NEDGE], s2_eycx_in [NEDGE];
   logic signed [PW-1:0] s2_excy_ff [NEDGE], s2_excy_in [NEDGE];
   logic        [XW-1:0] s2_ext_ff [NEDGE], s2_ext_in [NEDGE];

   // stage 3: projections of the edge and of the opposite vertex
   logic                 s3_valid_ff, s3_box_sep_ff;
   logic signed [DW-1:0] s3_da_ff [NEDGE], s3_da_in [NEDGE];
   logic signed [DW-1:0] s3_dc_ff [NEDGE], s3_dc_in [NEDGE];
   logic        [XW-1:0] s3_ext_ff [NEDGE];

   // stage 4: result
   logic                 rsp_valid_ff;
   logic                 rsp_overlaps_ff, rsp_overlaps_in;

   assign busy = 1'b0;
   assign s1_valid_in = start && !busy;

   assign vx[0] = req_x0;
   assign vy[0] = req_y0;
   assign vx[1] = req_x1;
   assign vy[1] = req_y1;
   assign vx[2] = req_x2;
   assign vy[2] = req_y2;

   always_comb begin
      logic lx, hx, ly, hy;
      lx = 1'b1;
      hx = 1'b1;
      ly = 1'b1;
      hy = 1'b1;
      for (int k = 0; k < NEDGE; k++) begin
         lx = lx && (CMPW'(vx[k]) < -ONE);
         hx = hx && (CMPW'(vx[k]) > ONE);
         ly = ly && (CMPW'(vy[k]) < -ONE);
         hy = hy && (CMPW'(vy[k]) > ONE);
         s1_ex_in[k] = EW'(vx[k]) - EW'(vx[EDGE_B[k]]);
         s1_ey_in[k] = EW'(vy[k]) - EW'(vy[EDGE_B[k]]);
      end
      s1_box_sep_in = lx || hx || ly || hy;
   end

   always_comb begin
      logic [EW-1:0] abs_x, abs_y;
      for (int k = 0; k < NEDGE; k++) begin
         s2_eyax_in[k] = PW'(s1_ey_ff[k]) * PW'(s1_ax_ff[k]);
         s2_exay_in[k] = PW'(s1_ex_ff[k]) * PW'(s1_ay_ff[k]);
         s2_eycx_in[k] = PW'(s1_ey_ff[k]) * PW'(s1_cx_ff[k]);
         s2_excy_in[k] = PW'(s1_ex_ff[k]) * PW'(s1_cy_ff[k]);
         abs_x = s1_ex_ff[k][EW-1] ? EW'(-s1_ex_ff[k]) : EW'(s1_ex_ff[k]);
         abs_y = s1_ey_ff[k][EW-1] ? EW'(-s1_ey_ff[k]) : EW'(s1_ey_ff[k]);
         s2_ext_in[k] = XW'((XW'(abs_x) + XW'(abs_y)) << FRAC);
      end
   end

   always_comb begin
      for (int k = 0; k < NEDGE; k++) begin
         s3_da_in[k] = DW'(s2_exay_ff[k]) - DW'(s2_eyax_ff[k]);
         s3_dc_in[k] = DW'(s2_excy_ff[k]) - DW'(s2_eycx_ff[k]);
      end
   end

   always_comb begin
      logic                   sep;
      logic signed [CMPW-1:0] ext, da, dc;
      sep = s3_box_sep_ff;
      for (int k = 0; k < NEDGE; k++) begin
         ext = $signed(CMPW'(s3_ext_ff[k]));
         da  = CMPW'(s3_da_ff[k]);
         dc  = CMPW'(s3_dc_ff[k]);
         sep = sep || (da > ext && dc > ext) || (da < -ext && dc < -ext);
      end
      rsp_overlaps_in = !sep;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_box_sep_ff   <= s1_box_sep_in;
      s2_box_sep_ff   <= s1_box_sep_ff;
      s3_box_sep_ff   <= s2_box_sep_ff;
      rsp_overlaps_ff <= rsp_overlaps_in;
      for (int k = 0; k < NEDGE; k++) begin
         s1_ex_ff[k]   <= s1_ex_in[k];
         s1_ey_ff[k]   <= s1_ey_in[k];
         s1_ax_ff[k]   <= vx[k];
         s1_ay_ff[k]   <= vy[k];
         s1_cx_ff[k]   <= vx[EDGE_C[k]];
         s1_cy_ff[k]   <= vy[EDGE_C[k]];
         s2_eyax_ff[k] <= s2_eyax_in[k];
         s2_exay_ff[k] <= s2_exay_in[k];
         s2_eycx_ff[k] <= s2_eycx_in[k];
         s2_excy_ff[k] <= s2_excy_in[k];
         s2_ext_ff[k]  <= s2_ext_in[k];
         s3_da_ff[k]   <= s3_da_in[k];
         s3_dc_ff[k]   <= s3_dc_in[k];
         s3_ext_ff[k]  <= s2_ext_ff[k];
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_overlaps = rsp_overlaps_ff;

   `TUB_ASSERT_IMPL(a_req_to_rsp, clock, reset, start && !busy, ##4 rsp_valid, "request lost in pipeline")
   `TUB_ASSERT_IMPL(a_rsp_from_req, clock, reset, rsp_valid, $past(start, 4), "response without request")
   `TUB_ASSERT_IMPL(a_box_sep, clock, reset, s1_valid_ff && s1_box_sep_ff, ##3 !rsp_overlaps, "box axis separation ignored")
   `TUB_ASSERT_NEXT(a_stage_adv, clock, reset, s2_valid_ff, s3_valid_ff, "stage 3 dropped a request")

endmodule

>>> sim/tb_triangle_unit_box_overlap_test_core.sv
// Testbench for triangle_unit_box_overlap_test_core: directed and random triangles
// against an in-bench separating-axis predictor, checked in order at rsp_valid.
// Depends on tubo_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_triangle_unit_box_overlap_test_core;
   import tubo_pkg::*;

   localparam int UNIT_ONE     = 1 << FRAC;
   localparam int COORD_MAX    = (1 << (CW - 1)) - 1;
   localparam int COORD_MIN    = -(1 << (CW - 1));
   localparam int CYCLE_LIMIT  = 200000;
   localparam int SETTLE_TICKS = 8;

   typedef struct packed {
      logic signed [CW-1:0] x0;
      logic signed [CW-1:0] y0;
      logic signed [CW-1:0] x1;
      logic signed [CW-1:0] y1;
      logic signed [CW-1:0] x2;
      logic signed [CW-1:0] y2;
   } triangle_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   triangle_type req_tri = '0;
   logic         busy;
   logic         rsp_valid;
   logic         rsp_overlaps;

   bit expected_overlap [$];
   int mismatches   = 0;
   int sent_count   = 0;
   int overlap_seen = 0;
   int apart_seen   = 0;
   int cycle_count  = 0;
   int burst_left   = 0;
   bit bursty       = 1'b1;

   triangle_unit_box_overlap_test_core dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_x0       (req_tri.x0),
      .req_y0       (req_tri.y0),
      .req_x1       (req_tri.x1),
      .req_y1       (req_tri.y1),
      .req_x2       (req_tri.x2),
      .req_y2       (req_tri.y2),
      .rsp_valid    (rsp_valid),
      .rsp_overlaps (rsp_overlaps)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic triangle_type make_triangle(input int ax, input int ay, input int bx,
                                                  input int by, input int cx, input int cy);
      triangle_type t;
      t.x0 = CW'(ax);
      t.y0 = CW'(ay);
      t.x1 = CW'(bx);
      t.y1 = CW'(by);
      t.x2 = CW'(cx);
      t.y2 = CW'(cy);
      return t;
   endfunction

   // Normal of edge a-b is (-ey, ex); the box reaches (|ex| + |ey|) * 1.0 along it.
   function automatic bit edge_separates_box(input longint ax, input longint ay,
                                             input longint bx, input longint by,
                                             input longint cx, input longint cy);
      longint ex, ey, pa, pc, lo, hi, reach;
      ex    = ax - bx;
      ey    = ay - by;
      pa    = ex * ay - ey * ax;
      pc    = ex * cy - ey * cx;
      lo    = (pc < pa) ? pc : pa;
      hi    = (pc < pa) ? pa : pc;
      reach = ((ex < 0 ? -ex : ex) + (ey < 0 ? -ey : ey)) <<< FRAC;
      return (lo > reach) || (hi < -reach);
   endfunction

   function automatic bit predict_overlap(input triangle_type t);
      longint x0, y0, x1, y1, x2, y2, u;
      bit     apart;
      x0 = $signed(t.x0);
      y0 = $signed(t.y0);
      x1 = $signed(t.x1);
      y1 = $signed(t.y1);
      x2 = $signed(t.x2);
      y2 = $signed(t.y2);
      u  = UNIT_ONE;
      apart = (x0 < -u && x1 < -u && x2 < -u) || (x0 > u && x1 > u && x2 > u) ||
              (y0 < -u && y1 < -u && y2 < -u) || (y0 > u && y1 > u && y2 > u);
      apart = apart || edge_separates_box(x0, y0, x1, y1, x2, y2)
                    || edge_separates_box(x1, y1, x2, y2, x0, y0)
                    || edge_separates_box(x2, y2, x0, y0, x1, y1);
      return !apart;
   endfunction

   function automatic int rand_coord(input int mode);
      int c;
      case (mode)
         0: c = int'($urandom_range(0, 2 * COORD_MAX + 1)) - (COORD_MAX + 1);
         1: c = int'($urandom_range(0, 6 * UNIT_ONE)) - 3 * UNIT_ONE;
         2: begin
            case ($urandom_range(0, 4))
               0: c = -UNIT_ONE;
               1: c = UNIT_ONE;
               2: c = -2 * UNIT_ONE;
               3: c = 2 * UNIT_ONE;
               default: c = 0;
            endcase
            c = c + int'($urandom_range(0, 4)) - 2;
         end
         default: c = int'($urandom_range(0, 128 * UNIT_ONE)) - 64 * UNIT_ONE;
      endcase
      return c;
   endfunction

   function automatic triangle_type random_triangle();
      triangle_type t;
      int           sel, mode;
      sel  = $urandom_range(0, 9);
      mode = (sel < 2) ? 0 : (sel < 6 || sel == 8) ? 1 : (sel < 8) ? 2 : 3;
      t = make_triangle(rand_coord(mode), rand_coord(mode), rand_coord(mode),
                        rand_coord(mode), rand_coord(mode), rand_coord(mode));
      if (sel == 8) begin
         case ($urandom_range(0, 3))
            0: begin t.x1 = t.x0; t.y1 = t.y0; end
            1: begin t.x2 = t.x1; t.y2 = t.y1; end
            2: begin t.x0 = t.x2; t.y0 = t.y2; end
            default: begin
               t.x1 = t.x0; t.y1 = t.y0;
               t.x2 = t.x0; t.y2 = t.y0;
            end
         endcase
      end
      return t;
   endfunction

   task automatic report_mismatch(input string what);
      mismatches++;
      $display("[%0t] %s", $time, what);
   endtask

   // Hold start low for a random gap at the head of each burst.
   task automatic send_triangle(input triangle_type t);
      int gap;
      if (bursty && burst_left == 0) begin
         gap = $urandom_range(1, 9);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = $urandom_range(1, 24);
      end
      if (burst_left > 0)
         burst_left--;
      start   <= 1'b1;
      req_tri <= t;
      @(posedge clock);
      while (busy) @(posedge clock);
      sent_count++;
   endtask

   task automatic wait_for_results();
      start <= 1'b0;
      do @(posedge clock); while (expected_overlap.size() != 0);
   endtask

   task automatic test_directed();
      localparam int U = UNIT_ONE;
      send_triangle(make_triangle(0, 0, U / 2, 0, 0, U / 2));
      send_triangle(make_triangle(-U - 1, 0, -3 * U, U, -2 * U, -U));
      send_triangle(make_triangle(U + 1, 0, 3 * U, U, 2 * U, -U));
      send_triangle(make_triangle(0, -U - 1, U, -3 * U, -U, -2 * U));
      send_triangle(make_triangle(0, U + 1, U, 3 * U, -U, 2 * U));
      send_triangle(make_triangle(U, 0, 3 * U, U, 2 * U, -U));
      send_triangle(make_triangle(0, -U, U, -3 * U, -U, -2 * U));
      send_triangle(make_triangle(2 * U, 0, 0, 2 * U, 3 * U, 3 * U));
      send_triangle(make_triangle(2 * U + 1, 0, 0, 2 * U + 1, 3 * U, 3 * U));
      send_triangle(make_triangle(0, 2 * U + 1, 2 * U + 1, 0, 3 * U, 3 * U));
      send_triangle(make_triangle(-2 * U - 1, 0, 0, -2 * U - 1, -3 * U, -3 * U));
      send_triangle(make_triangle(-2 * U, 0, 0, -2 * U, -3 * U, -3 * U));
      send_triangle(make_triangle(-4 * U, -4 * U, 4 * U, -4 * U, 0, 4 * U));
      send_triangle(make_triangle(0, 0, 0, 0, 0, 0));
      send_triangle(make_triangle(U, U, U, U, U, U));
      send_triangle(make_triangle(U + 1, U + 1, U + 1, U + 1, U + 1, U + 1));
      send_triangle(make_triangle(-3 * U, 0, -3 * U, 0, 3 * U, 0));
      send_triangle(make_triangle(2 * U + 1, 0, 2 * U + 1, 0, 0, 2 * U + 1));
      send_triangle(make_triangle(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                                  COORD_MAX, COORD_MAX));
      send_triangle(make_triangle(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                                  COORD_MIN, COORD_MIN));
      send_triangle(make_triangle(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN, 0, COORD_MAX));
      send_triangle(make_triangle(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, -1, -1));
      send_triangle(make_triangle(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                                  COORD_MIN, COORD_MIN));
      send_triangle(make_triangle(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN,
                                  COORD_MAX, COORD_MAX));
   endtask

   task automatic test_random_bursts(input int count);
      bursty = 1'b1;
      repeat (count) send_triangle(random_triangle());
   endtask

   task automatic test_back_to_back(input int count);
      bursty = 1'b0;
      repeat (count) send_triangle(random_triangle());
      bursty = 1'b1;
   endtask

   always @(posedge clock) begin : check_results
      bit want;
      if (!reset) begin
         if (start && !busy)
            expected_overlap.push_back(predict_overlap(req_tri));
         if (rsp_valid === 1'b1) begin
            if (expected_overlap.size() == 0) begin
               report_mismatch("result with no request outstanding");
            end else begin
               want = expected_overlap.pop_front();
               if (rsp_overlaps !== want)
                  report_mismatch($sformatf("overlaps %b, predicted %b", rsp_overlaps, want));
               if (want)
                  overlap_seen++;
               else
                  apart_seen++;
            end
         end else if (rsp_valid !== 1'b0) begin
            report_mismatch("rsp_valid unknown");
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("triangle_unit_box_overlap_test_core: mismatch");
         $finish;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      wait_for_results();
      test_random_bursts(800);
      wait_for_results();
      test_back_to_back(300);
      wait_for_results();
      test_random_bursts(600);
      wait_for_results();
      repeat (SETTLE_TICKS) @(posedge clock);
      if (expected_overlap.size() != 0)
         report_mismatch("results still outstanding at end of run");
      $display("Sent %0d triangles (directed edge, corner, degenerate and extreme cases,",
               sent_count);
      $display("then bursty and back-to-back random): %0d overlapping, %0d separated.",
               overlap_seen, apart_seen);
      if (mismatches == 0) begin
         $display("triangle_unit_box_overlap_test_core: match");
      end else begin
         $display("triangle_unit_box_overlap_test_core: mismatch");
      end
      $finish;
   end

endmodule
